>>> hw/rtl/csom_pkg.sv
// Package for the connection slot owner manager.
// Holds the command and mark codes, register indexes and the structs that
// travel between the controller and the slot cells. No dependencies.
package csom_pkg;

    // Command codes of the input transfer.
    localparam logic [3:0] CMD_CONNECT    = 4'd0;
    localparam logic [3:0] CMD_DISCONNECT = 4'd1;
    localparam logic [3:0] CMD_CLAIM      = 4'd2;
    localparam logic [3:0] CMD_RELEASE    = 4'd3;
    localparam logic [3:0] CMD_OPEN       = 4'd4;
    localparam logic [3:0] CMD_CLOSE      = 4'd5;
    localparam logic [3:0] CMD_PENDING    = 4'd6;
    localparam logic [3:0] CMD_FAILED     = 4'd7;
    localparam logic [3:0] CMD_QUERY      = 4'd8;

    // Delete marks of a slot.
    localparam logic [1:0] MARK_NONE    = 2'd0;
    localparam logic [1:0] MARK_PENDING = 2'd1;
    localparam logic [1:0] MARK_FAILED  = 2'd2;

    // Configuration register indexes.
    localparam logic REG_WINDOW   = 1'b0;
    localparam logic REG_CAPACITY = 1'b1;

    // Slot index and count fields cover the largest supported slot table (16).
    localparam int SLOT_IDX_W = 4;
    localparam int SLOT_CNT_W = 5;

    // Slot write operations.
    localparam logic [1:0] WR_NONE  = 2'd0;
    localparam logic [1:0] WR_SET   = 2'd1;
    localparam logic [1:0] WR_CLEAR = 2'd2;
    localparam logic [1:0] WR_MARK  = 2'd3;

    // Search record handed from cell to cell.
    typedef struct packed {
        logic                  hit;
        logic [SLOT_IDX_W-1:0] hit_idx;
        logic [31:0]           hit_gen;
        logic [1:0]            hit_mark;
        logic                  free;
        logic [SLOT_IDX_W-1:0] free_idx;
        logic [SLOT_CNT_W-1:0] count;
    } t_probe;

    // Update broadcast from the controller to all cells.
    typedef struct packed {
        logic [1:0]            op;
        logic [SLOT_IDX_W-1:0] idx;
        logic [15:0]           handle;
        logic [31:0]           gen;
        logic [1:0]            mark;
    } t_slot_wr;

endpackage

>>> hw/rtl/csom_cell.sv
// One connection slot cell: holds handle, generation and delete mark of a slot
// and passes the registered search record to its neighbor. Depends on csom_pkg.
module csom_cell #(
    parameter logic [3:0] SLOT_ID = 4'd0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [15:0]       i_handle,
    input  csom_pkg::t_probe  i_probe,
    input  csom_pkg::t_slot_wr i_wr,
    output csom_pkg::t_probe  o_probe
);
    import csom_pkg::*;

    logic        r_used;
    logic [15:0] r_handle;
    logic [31:0] r_gen;
    logic [1:0]  r_mark;
    t_probe      n_probe;
    t_probe      r_probe;

    // Merge this slot into the search record: first match and first free slot win.
    always_comb begin
        n_probe = i_probe;
        if (!i_probe.hit && r_used && (r_handle == i_handle)) begin
            n_probe.hit      = 1'b1;
            n_probe.hit_idx  = SLOT_ID;
            n_probe.hit_gen  = r_gen;
            n_probe.hit_mark = r_mark;
        end
        if (!i_probe.free && !r_used) begin
            n_probe.free     = 1'b1;
            n_probe.free_idx = SLOT_ID;
        end
        n_probe.count = i_probe.count + SLOT_CNT_W'(r_used);
    end

    // The search record moves one cell per cycle.
    always_ff @(posedge i_clk) begin
        r_probe <= n_probe;
    end

    assign o_probe = r_probe;

    // Slot contents, updated by the controller at the end of a command.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= 1'b0;
            r_handle <= '0;
            r_gen    <= '0;
            r_mark   <= MARK_NONE;
        end else if (i_wr.idx == SLOT_ID) begin
            unique case (i_wr.op)
                WR_SET: begin
                    r_used   <= 1'b1;
                    r_handle <= i_wr.handle;
                    r_gen    <= i_wr.gen;
                    r_mark   <= MARK_NONE;
                end
                WR_CLEAR: begin
                    r_used   <= 1'b0;
                    r_handle <= '0;
                    r_gen    <= '0;
                    r_mark   <= MARK_NONE;
                end
                WR_MARK: begin
                    r_mark <= i_wr.mark;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

>>> hw/rtl/connection_slot_owner_manager.sv
// Top level of the connection slot owner manager: command controller, lock,
// pairing window and the chain of slot cells. Depends on csom_pkg, csom_cell.
//
// Usage: one command enters per transfer on the slave stream (command code in
// s_tuser, operands in s_tdata) and exactly one result leaves on the master
// stream (m_tdata). Commands connect, disconnect, claim or release the motion
// lock, open or close the pairing window, set delete marks or query a handle.
// A command is accepted, then the search record walks the row of slot cells,
// and then state is updated and the result register loaded. The slave side
// is ready only between commands.
// If the receiver stalls, the result waits in the output register; the next
// command may still be accepted and searched, and its commit waits until the
// held result has been transferred.
// Reset empties all slots, drops the lock, closes the window, clears the
// generation counter and loads the window length (60000 ms) and bond
// capacity (8). Configuration writes are taken in any cycle, no wait states.
module connection_slot_owner_manager #(
    parameter int SLOT_COUNT = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Command stream. s_tuser: cmd[3:0]. s_tdata: handle[15:0],
    // conn_generation[47:16], now_ms[79:48], bonds[87:80].
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [3:0]  s_tuser,
    input  logic [87:0] s_tdata,
    // Result stream. m_tdata: ok[0], slot_index[2:1], slot_gen_out[34:3],
    // lock_owner[35], slot_delete_mark[37:36], connection_count[40:38],
    // lock_held[41], window_open[42], window_remaining_ms[73:43],
    // may_pair[74], zero [79:75].
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [30:0] i_cfg_data
);
    import csom_pkg::*;

    localparam int CNT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_DONE   = 2'd2;

    logic [1:0]       r_state;
    logic [CNT_W-1:0] r_cnt;

    logic [3:0]  r_cmd;
    logic [15:0] r_handle;
    logic [31:0] r_cgen;
    logic [31:0] r_now;
    logic [7:0]  r_bonds;

    logic [30:0] r_window_ms;
    logic [7:0]  r_capacity;
    logic [31:0] r_gen_counter;
    logic        r_owner_valid;
    logic [15:0] r_owner_handle;
    logic [31:0] r_owner_gen;
    logic        r_open_flag;
    logic [31:0] r_deadline;

    logic        r_out_valid;
    logic [79:0] r_out_data;

    t_probe   w_probe [SLOT_COUNT+1];
    t_probe   p_tail;
    t_slot_wr w_wr;

    logic        w_commit;
    logic        n_ok;
    logic [SLOT_IDX_W-1:0] n_idx;
    logic [31:0] n_sgen;
    logic        n_was;
    logic [1:0]  n_mark;
    logic [SLOT_CNT_W-1:0] n_count;
    logic [31:0] n_gen_counter;
    logic        n_owner_valid;
    logic [15:0] n_owner_handle;
    logic [31:0] n_owner_gen;
    logic        n_open_flag;
    logic [31:0] n_deadline;
    logic        n_open;
    logic [31:0] n_diff;
    logic [31:0] n_remain;
    logic        n_may;
    logic [31:0] w_gen_inc;

    // Row of slot cells; the first cell starts from an empty search record.
    assign w_probe[0] = '0;
    for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
        csom_cell #(
            .SLOT_ID (4'(g))
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_handle (r_handle),
            .i_probe  (w_probe[g]),
            .i_wr     (w_wr),
            .o_probe  (w_probe[g+1])
        );
    end
    assign p_tail = w_probe[SLOT_COUNT];

    assign s_tready = (r_state == S_IDLE);
    assign w_commit = (r_state == S_DONE) && (!r_out_valid || m_tready);
    assign w_gen_inc = r_gen_counter + 32'd1;

    // Command decision from the finished search record.
    always_comb begin
        n_ok           = 1'b0;
        n_idx          = '0;
        n_sgen         = '0;
        n_was          = 1'b0;
        n_mark         = MARK_NONE;
        n_count        = p_tail.count;
        n_gen_counter  = r_gen_counter;
        n_owner_valid  = r_owner_valid;
        n_owner_handle = r_owner_handle;
        n_owner_gen    = r_owner_gen;
        n_open_flag    = r_open_flag;
        n_deadline     = r_deadline;
        w_wr           = '0;
        w_wr.op        = WR_NONE;
        w_wr.handle    = r_handle;
        unique case (r_cmd)
            CMD_CONNECT: begin
                if (!p_tail.hit && p_tail.free) begin
                    n_gen_counter = (w_gen_inc == 32'd0) ? 32'd1 : w_gen_inc;
                    w_wr.op  = WR_SET;
                    w_wr.idx = p_tail.free_idx;
                    w_wr.gen = n_gen_counter;
                    n_ok     = 1'b1;
                    n_idx    = p_tail.free_idx;
                    n_sgen   = n_gen_counter;
                    n_count  = p_tail.count + SLOT_CNT_W'(1);
                end
            end
            CMD_DISCONNECT: begin
                if (p_tail.hit && (p_tail.hit_gen == r_cgen)) begin
                    if (r_owner_valid && (r_owner_handle == r_handle)
                            && (r_owner_gen == r_cgen)) begin
                        n_was          = 1'b1;
                        n_owner_valid  = 1'b0;
                        n_owner_handle = '0;
                        n_owner_gen    = '0;
                    end
                    w_wr.op  = WR_CLEAR;
                    w_wr.idx = p_tail.hit_idx;
                    n_ok     = 1'b1;
                    n_idx    = p_tail.hit_idx;
                    n_sgen   = p_tail.hit_gen;
                    n_count  = p_tail.count - SLOT_CNT_W'(1);
                end
            end
            CMD_CLAIM: begin
                if (p_tail.hit) begin
                    n_idx  = p_tail.hit_idx;
                    n_sgen = p_tail.hit_gen;
                    n_mark = p_tail.hit_mark;
                    if ((p_tail.hit_mark != MARK_PENDING) && (!r_owner_valid
                            || ((r_owner_handle == r_handle)
                            && (r_owner_gen == p_tail.hit_gen)))) begin
                        n_owner_valid  = 1'b1;
                        n_owner_handle = r_handle;
                        n_owner_gen    = p_tail.hit_gen;
                        n_ok           = 1'b1;
                    end
                end
            end
            CMD_RELEASE: begin
                n_ok           = r_owner_valid;
                n_owner_valid  = 1'b0;
                n_owner_handle = '0;
                n_owner_gen    = '0;
            end
            CMD_OPEN: begin
                n_open_flag = 1'b1;
                n_deadline  = r_now + {1'b0, r_window_ms};
                n_ok        = 1'b1;
            end
            CMD_CLOSE: begin
                n_open_flag = 1'b0;
                n_deadline  = '0;
                n_ok        = 1'b1;
            end
            CMD_PENDING, CMD_FAILED: begin
                if (p_tail.hit) begin
                    w_wr.op   = WR_MARK;
                    w_wr.idx  = p_tail.hit_idx;
                    w_wr.mark = (r_cmd == CMD_PENDING) ? MARK_PENDING : MARK_FAILED;
                    n_ok      = 1'b1;
                    n_idx     = p_tail.hit_idx;
                    n_sgen    = p_tail.hit_gen;
                    n_mark    = w_wr.mark;
                end
            end
            CMD_QUERY: begin
                n_ok = 1'b1;
                if (p_tail.hit) begin
                    n_idx  = p_tail.hit_idx;
                    n_sgen = p_tail.hit_gen;
                    n_mark = p_tail.hit_mark;
                end
            end
            default: begin
            end
        endcase

        // Window status after the command: it closes once the deadline is reached.
        n_diff = r_now - n_deadline;
        n_open = n_open_flag && n_diff[31];
        if (!n_open) begin
            n_open_flag = 1'b0;
            n_deadline  = '0;
        end
        n_remain = n_open ? (n_deadline - r_now) : 32'd0;
        n_may    = (r_capacity != 8'd0) && (r_bonds < r_capacity) && n_open;

        // Slot writes happen only in the commit cycle.
        if (!w_commit) begin
            w_wr.op = WR_NONE;
        end
    end

    // Command sequencer: accept, walk the cell row, commit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (s_tvalid) begin
                        r_state <= S_SEARCH;
                        r_cnt   <= '0;
                    end
                end
                S_SEARCH: begin
                    if (r_cnt == CNT_W'(SLOT_COUNT - 1)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                S_DONE: begin
                    if (w_commit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Command fields are captured at the input transfer.
    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_cmd    <= s_tuser;
            r_handle <= s_tdata[15:0];
            r_cgen   <= s_tdata[47:16];
            r_now    <= s_tdata[79:48];
            r_bonds  <= s_tdata[87:80];
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_ms <= 31'd60000;
            r_capacity  <= 8'd8;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_WINDOW:   r_window_ms <= i_cfg_data;
                REG_CAPACITY: r_capacity  <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // Generation counter, motion lock and pairing window.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen_counter  <= '0;
            r_owner_valid  <= 1'b0;
            r_owner_handle <= '0;
            r_owner_gen    <= '0;
            r_open_flag    <= 1'b0;
            r_deadline     <= '0;
        end else if (w_commit) begin
            r_gen_counter  <= n_gen_counter;
            r_owner_valid  <= n_owner_valid;
            r_owner_handle <= n_owner_handle;
            r_owner_gen    <= n_owner_gen;
            r_open_flag    <= n_open_flag;
            r_deadline     <= n_deadline;
        end
    end

    // Result register of the master stream.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_data <= {5'd0, n_may, n_remain[30:0], n_open, n_owner_valid,
                           n_count[2:0], n_mark, n_was, n_sgen, n_idx[1:0], n_ok};
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;

    // The reported slot count never exceeds the table size.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[40:38] <= 3'(SLOT_COUNT)))
        else $error("connection count above slot count");

    // An accepted command always starts a fresh walk of the cell row.
    a_accept_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> ((r_state == S_SEARCH) && (r_cnt == '0)))
        else $error("accepted command did not start a search");

    // A commit always loads a result and returns to idle.
    a_commit_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> (m_tvalid && (r_state == S_IDLE)))
        else $error("commit without result");

endmodule

>>> tb/sv/csom_result_checker.sv
// Result checker for the connection slot owner manager: a command-level model of
// the slot table, motion lock and pairing window that predicts every result.
// Depends on csom_pkg for the command, mark and register codes.
module csom_result_checker #(
    parameter int SLOT_COUNT = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // cmd.
    input  logic [3:0]  s_tuser,
    // handle, conn_generation, now_ms, bonds.
    input  logic [87:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // ok, slot_index, slot_gen_out, lock_owner, slot_delete_mark,
    // connection_count, lock_held, window_open, window_remaining_ms, may_pair.
    input  logic [79:0] m_tdata,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [30:0] i_cfg_data,
    output int          o_error_count,
    output int          o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import csom_pkg::*;

    // One result, packed so that it maps directly onto m_tdata[74:0].
    typedef struct packed {
        logic        may;
        logic [30:0] remaining;
        logic        wopen;
        logic        lock;
        logic [2:0]  count;
        logic [1:0]  mark;
        logic        was;
        logic [31:0] gen;
        logic [1:0]  idx;
        logic        ok;
    } t_slot_result;

    // Model state.
    logic [30:0] window_len;
    logic [7:0]  capacity;
    logic        used_tab   [SLOT_COUNT];
    logic [15:0] handle_tab [SLOT_COUNT];
    logic [31:0] gen_tab    [SLOT_COUNT];
    logic [1:0]  mark_tab   [SLOT_COUNT];
    logic [31:0] gen_ctr;
    logic        owner_valid;
    logic [15:0] owner_handle;
    logic [31:0] owner_gen;
    logic        window_flag;
    logic [31:0] window_deadline;

    // Results predicted for accepted commands, oldest first.
    t_slot_result pending_replies[$];

    function automatic int find_handle(input logic [15:0] h);
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (used_tab[i] && handle_tab[i] == h) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic string describe_result(input t_slot_result r);
        return $sformatf({"ok=%0d slot=%0d gen=%08h lock_owner=%0d mark=%0d count=%0d ",
                          "lock=%0d open=%0d remaining=%0d may_pair=%0d"},
                         r.ok, r.idx, r.gen, r.was, r.mark, r.count, r.lock,
                         r.wopen, r.remaining, r.may);
    endfunction

    // Apply one command to the model and work out its result.
    // The command word holds the code in its low four bits and the operands above.
    task automatic apply_slot_command(input logic [91:0] d, output t_slot_result r);
        logic [3:0]  cmd;
        logic [15:0] h;
        logic [31:0] g;
        logic [31:0] now_v;
        logic [31:0] diff;
        logic [7:0]  bonds;
        logic        open_now;
        int          hit;
        int          sel;
        int          spare;
        int          i;
        cmd   = d[3:0];
        h     = d[19:4];
        g     = d[51:20];
        now_v = d[83:52];
        bonds = d[91:84];
        r     = '0;
        sel   = -1;
        spare = -1;
        hit   = find_handle(h);
        case (cmd)
            CMD_CONNECT: begin
                if (hit < 0) begin
                    for (i = 0; i < SLOT_COUNT; i++) begin
                        if (!used_tab[i] && spare < 0) begin
                            spare = i;
                        end
                    end
                    // The generation counter skips zero when it wraps.
                    if (spare >= 0) begin
                        gen_ctr = gen_ctr + 1;
                        if (gen_ctr == 0) begin
                            gen_ctr = 1;
                        end
                        used_tab[spare]   = 1'b1;
                        handle_tab[spare] = h;
                        gen_tab[spare]    = gen_ctr;
                        mark_tab[spare]   = MARK_NONE;
                        r.ok = 1'b1;
                        sel  = spare;
                    end
                end
            end
            CMD_DISCONNECT: begin
                if (hit >= 0 && gen_tab[hit] == g) begin
                    if (owner_valid && owner_handle == h && owner_gen == g) begin
                        r.was        = 1'b1;
                        owner_valid  = 1'b0;
                        owner_handle = '0;
                        owner_gen    = '0;
                    end
                    r.ok  = 1'b1;
                    r.idx = 2'(hit);
                    r.gen = gen_tab[hit];
                    used_tab[hit]   = 1'b0;
                    handle_tab[hit] = '0;
                    gen_tab[hit]    = '0;
                    mark_tab[hit]   = MARK_NONE;
                end
            end
            CMD_CLAIM: begin
                sel = hit;
                if (hit >= 0 && mark_tab[hit] != MARK_PENDING) begin
                    if (!owner_valid || (owner_handle == h && owner_gen == gen_tab[hit])) begin
                        owner_valid  = 1'b1;
                        owner_handle = h;
                        owner_gen    = gen_tab[hit];
                        r.ok = 1'b1;
                    end
                end
            end
            CMD_RELEASE: begin
                r.ok         = owner_valid;
                owner_valid  = 1'b0;
                owner_handle = '0;
                owner_gen    = '0;
            end
            CMD_OPEN: begin
                window_flag     = 1'b1;
                window_deadline = now_v + {1'b0, window_len};
                r.ok = 1'b1;
            end
            CMD_CLOSE: begin
                window_flag     = 1'b0;
                window_deadline = '0;
                r.ok = 1'b1;
            end
            CMD_PENDING, CMD_FAILED: begin
                sel = hit;
                if (hit >= 0) begin
                    mark_tab[hit] = (cmd == CMD_PENDING) ? MARK_PENDING : MARK_FAILED;
                    r.ok = 1'b1;
                end
            end
            CMD_QUERY: begin
                sel  = hit;
                r.ok = 1'b1;
            end
            default: begin
            end
        endcase

        if (sel >= 0) begin
            r.idx  = 2'(sel);
            r.gen  = gen_tab[sel];
            r.mark = mark_tab[sel];
        end
        for (i = 0; i < SLOT_COUNT; i++) begin
            r.count = r.count + 3'(used_tab[i]);
        end

        // The window closes once now_ms has reached the deadline, modulo 2^32.
        open_now = 1'b0;
        if (window_flag) begin
            diff = now_v - window_deadline;
            if (!diff[31]) begin
                window_flag     = 1'b0;
                window_deadline = '0;
            end else begin
                open_now = 1'b1;
            end
        end
        r.wopen = open_now;
        if (open_now) begin
            r.remaining = 31'(window_deadline - now_v);
        end
        r.lock = owner_valid;
        r.may  = (capacity != 0) && (bonds < capacity) && open_now;
    endtask

    // Track configuration, commands and results at every clock edge.
    always @(posedge i_clk) begin
        t_slot_result got;
        t_slot_result want;
        if (!i_rst_n) begin
            o_error_count   = 0;
            window_len      = 31'd60000;
            capacity        = 8'd8;
            gen_ctr         = '0;
            owner_valid     = 1'b0;
            owner_handle    = '0;
            owner_gen       = '0;
            window_flag     = 1'b0;
            window_deadline = '0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                used_tab[i]   = 1'b0;
                handle_tab[i] = '0;
                gen_tab[i]    = '0;
                mark_tab[i]   = MARK_NONE;
            end
            pending_replies.delete();
        end else begin
            // A result transfer is checked against the oldest prediction.
            if (m_tvalid && m_tready) begin
                got = t_slot_result'(m_tdata[74:0]);
                if (pending_replies.size() == 0) begin
                    if (o_error_count < 10) begin
                        $display("[%0t] ERROR: unexpected result: %s", $realtime,
                                 describe_result(got));
                    end
                    o_error_count++;
                end else begin
                    want = pending_replies.pop_front();
                    if (got.ok !== want.ok || got.idx !== want.idx || got.gen !== want.gen
                        || got.was !== want.was || got.mark !== want.mark
                        || got.count !== want.count || got.lock !== want.lock
                        || got.wopen !== want.wopen || got.remaining !== want.remaining
                        || got.may !== want.may) begin
                        if (o_error_count < 10) begin
                            $display("[%0t] ERROR: result mismatch", $realtime);
                            $display("    expected %s", describe_result(want));
                            $display("    actual   %s", describe_result(got));
                        end
                        o_error_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_addr == REG_WINDOW) begin
                    window_len = i_cfg_data;
                end else begin
                    capacity = i_cfg_data[7:0];
                end
            end
            if (s_tvalid && s_tready) begin
                apply_slot_command({s_tdata, s_tuser}, want);
                pending_replies.push_back(want);
            end
        end
        o_outstanding = pending_replies.size();
    end

endmodule

>>> tb/sv/tb_connection_slot_owner_manager.sv
// Testbench top for the connection slot owner manager: clock, reset, command
// stimulus with bursty sender and stalling receiver, and the final verdict.
// Depends on csom_pkg, connection_slot_owner_manager and csom_result_checker.
module tb_connection_slot_owner_manager;
    timeunit 1ns;
    timeprecision 1ps;
    import csom_pkg::*;

    localparam int         SLOTS        = 4;
    localparam int         PHASE_ITEMS  = 200;
    // Highest code the command field can carry; everything above query is undefined.
    localparam logic [3:0] CMD_TOP_CODE = 4'hF;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        s_tvalid   = 1'b0;
    logic        s_tready;
    // cmd[3:0].
    logic [3:0]  s_tuser    = '0;
    // handle[15:0], conn_generation[47:16], now_ms[79:48], bonds[87:80].
    logic [87:0] s_tdata    = '0;
    logic        m_tvalid;
    logic        m_tready   = 1'b0;
    // ok[0], slot_index[2:1], slot_gen_out[34:3], lock_owner[35],
    // slot_delete_mark[37:36], connection_count[40:38], lock_held[41],
    // window_open[42], window_remaining_ms[73:43], may_pair[74], zero [79:75].
    logic [79:0] m_tdata;
    logic        i_cfg_we   = 1'b0;
    logic        i_cfg_addr = 1'b0;
    logic [30:0] i_cfg_data = '0;
    int          error_count;
    int          outstanding;

    // Stimulus bookkeeping: which handles are connected under which generation.
    logic        known_used   [SLOTS] = '{default: 1'b0};
    logic [15:0] known_handle [SLOTS] = '{default: 16'h0};
    logic [31:0] known_gen    [SLOTS] = '{default: 32'h0};
    logic [31:0] last_gen   = '0;
    logic [15:0] handle_pool [8];
    logic [31:0] clock_ms   = '0;
    int          burst_left = 1;
    int          ready_cycle = 0;
    int          ready_mode  = 0;

    connection_slot_owner_manager #(
        .SLOT_COUNT(SLOTS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data)
    );

    csom_result_checker #(
        .SLOT_COUNT(SLOTS)
    ) i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tuser       (s_tuser),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .o_error_count (error_count),
        .o_outstanding (outstanding)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Receiver: periodically picks at random among always ready, mostly ready,
    // a fixed periodic stall and coin-flip readiness.
    always @(posedge i_clk) begin
        ready_cycle++;
        if (ready_cycle % 256 == 0) begin
            ready_mode = $urandom_range(0, 3);
        end
        case (ready_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= ((ready_cycle % 5) < 2);
            default: m_tready <= $urandom_range(0, 1);
        endcase
    end

    // Both registers are written back to back while the block is idle.
    task automatic write_config(input logic [30:0] window_len, input logic [7:0] capacity);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= REG_WINDOW;
        i_cfg_data <= window_len;
        @(posedge i_clk);
        i_cfg_addr <= REG_CAPACITY;
        i_cfg_data <= {23'b0, capacity};
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Present one command, wait for its transfer, then maybe pause the stream.
    task automatic send_item(input logic [3:0] c, input logic [15:0] h, input logic [31:0] g,
                             input logic [31:0] now_v, input logic [7:0] bonds);
        int found;
        int spare;
        s_tvalid <= 1'b1;
        s_tuser  <= c;
        s_tdata  <= {bonds, now_v, g, h};
        do @(posedge i_clk); while (!s_tready);

        found = -1;
        spare = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (known_used[i] && known_handle[i] == h && found < 0) begin
                found = i;
            end
            if (!known_used[i] && spare < 0) begin
                spare = i;
            end
        end
        if (c == CMD_CONNECT && found < 0 && spare >= 0) begin
            last_gen = last_gen + 1;
            if (last_gen == 0) begin
                last_gen = 1;
            end
            known_used[spare]   = 1'b1;
            known_handle[spare] = h;
            known_gen[spare]    = last_gen;
        end else if (c == CMD_DISCONNECT && found >= 0 && known_gen[found] == g) begin
            known_used[found] = 1'b0;
        end

        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
            s_tvalid <= 1'b0;
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(4, 20)) @(posedge i_clk);
            end else begin
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
    endtask

    // Stop sending and wait until every result has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    // One random command: mostly pool handles so that the table fills and
    // disconnects, claims and marks hit live connections.
    task automatic random_command(input logic [7:0] capacity);
        int          pick;
        int          s;
        int          near;
        logic [3:0]  c;
        logic [15:0] h;
        logic [31:0] g;
        logic [7:0]  b;
        pick = $urandom_range(0, 99);
        h    = ($urandom_range(0, 6) == 0) ? 16'($urandom()) : handle_pool[$urandom_range(0, 7)];
        g    = $urandom();
        if (pick < 20) begin
            c = CMD_CONNECT;
        end else if (pick < 36) begin
            c = CMD_DISCONNECT;
            s = $urandom_range(0, SLOTS - 1);
            if (known_used[s] && $urandom_range(0, 5) != 0) begin
                h = known_handle[s];
                g = known_gen[s];
            end else if (known_used[s]) begin
                h = known_handle[s];
            end
        end else if (pick < 51) begin
            c = CMD_CLAIM;
        end else if (pick < 59) begin
            c = CMD_RELEASE;
        end else if (pick < 67) begin
            c = CMD_OPEN;
        end else if (pick < 71) begin
            c = CMD_CLOSE;
        end else if (pick < 78) begin
            c = CMD_PENDING;
        end else if (pick < 85) begin
            c = CMD_FAILED;
        end else if (pick < 96) begin
            c = CMD_QUERY;
        end else begin
            c = 4'($urandom_range(int'(CMD_QUERY) + 1, int'(CMD_TOP_CODE)));
        end

        // Bond counts cluster around the capacity half of the time.
        if ($urandom_range(0, 1) == 0) begin
            b = 8'($urandom_range(0, 255));
        end else begin
            near = int'(capacity) + $urandom_range(0, 4) - 2;
            b = (near < 0) ? 8'd0 : (near > 255) ? 8'd255 : 8'(near);
        end

        // Time mostly creeps forward, sometimes leaps, and rarely jumps anywhere.
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            clock_ms = clock_ms + $urandom_range(0, 8);
        end else if (pick < 95) begin
            clock_ms = clock_ms + $urandom_range(0, 3000);
        end else begin
            clock_ms = $urandom();
        end
        send_item(c, h, g, clock_ms, b);
    endtask

    task automatic run_phase(input logic [30:0] window_len, input logic [7:0] capacity);
        write_config(window_len, capacity);
        for (int i = 0; i < 8; i++) begin
            handle_pool[i] = 16'($urandom());
        end
        handle_pool[0] = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        clock_ms = 32'hFFFF_FF00 | 32'($urandom_range(0, 255));
        repeat (PHASE_ITEMS) random_command(capacity);
        drain();
    endtask

    // Main sequence: reset, directed commands, then random phases.
    initial begin
        burst_left = $urandom_range(1, 40);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with a 20 ms window and room for three bonds.
        write_config(31'd20, 8'd3);
        send_item(CMD_QUERY, 16'h0000, 32'h0, 32'd0, 8'd0);
        send_item(CMD_CONNECT, 16'h0000, 32'hFFFF_FFFF, 32'd0, 8'd255);
        send_item(CMD_CONNECT, 16'hFFFF, 32'h0, 32'd1, 8'd0);
        // Duplicate handle, then fill the table and overflow it.
        send_item(CMD_CONNECT, 16'h0000, 32'h0, 32'd2, 8'd0);
        send_item(CMD_CONNECT, 16'h1234, 32'h0, 32'd3, 8'd1);
        send_item(CMD_CONNECT, 16'h5678, 32'h0, 32'd4, 8'd2);
        send_item(CMD_CONNECT, 16'h9ABC, 32'h0, 32'd5, 8'd3);
        // Lock: take it, lose a contest for it, re-claim as owner.
        send_item(CMD_CLAIM, 16'hFFFF, 32'h0, 32'd6, 8'd0);
        send_item(CMD_CLAIM, 16'h0000, 32'h0, 32'd7, 8'd0);
        send_item(CMD_CLAIM, 16'hFFFF, 32'h0, 32'd8, 8'd0);
        // The owner disconnects and the lock goes with it.
        send_item(CMD_DISCONNECT, 16'hFFFF, 32'd2, 32'd9, 8'd0);
        // Delete marks: pending blocks a claim, failed does not.
        send_item(CMD_PENDING, 16'h1234, 32'h0, 32'd10, 8'd0);
        send_item(CMD_CLAIM, 16'h1234, 32'h0, 32'd11, 8'd0);
        send_item(CMD_FAILED, 16'h5678, 32'h0, 32'd12, 8'd0);
        send_item(CMD_CLAIM, 16'h5678, 32'h0, 32'd13, 8'd0);
        send_item(CMD_PENDING, 16'h4242, 32'h0, 32'd14, 8'd0);
        send_item(CMD_RELEASE, 16'hFFFF, 32'h0, 32'd15, 8'd0);
        send_item(CMD_RELEASE, 16'h0000, 32'h0, 32'd16, 8'd0);
        send_item(CMD_DISCONNECT, 16'h0000, 32'hFFFF_FFFF, 32'd17, 8'd0);
        // Window whose deadline wraps past zero, then expires exactly on time.
        send_item(CMD_OPEN, 16'h0000, 32'h0, 32'hFFFF_FFF0, 8'd2);
        send_item(CMD_QUERY, 16'h1234, 32'h0, 32'd2, 8'd3);
        send_item(CMD_QUERY, 16'h5678, 32'h0, 32'd4, 8'd0);
        send_item(CMD_OPEN, 16'h0000, 32'h0, 32'd100, 8'd0);
        send_item(CMD_CLOSE, 16'h0000, 32'h0, 32'd101, 8'd1);
        send_item(CMD_TOP_CODE, 16'h5678, 32'hFFFF_FFFF, 32'd102, 8'd0);
        drain();

        // Random phases across window and capacity settings, extremes included.
        run_phase(31'd1, 8'd1);
        run_phase(31'd0, 8'd0);
        run_phase(31'h7FFF_FFFF, 8'd255);
        run_phase(31'd500, 8'd8);
        run_phase(31'd60000, 8'd4);
        run_phase(31'($urandom_range(2, 100000)), 8'($urandom_range(1, 254)));

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #1_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/csom_pkg.sv
hw/rtl/csom_cell.sv
hw/rtl/connection_slot_owner_manager.sv
tb/sv/csom_result_checker.sv
tb/sv/tb_connection_slot_owner_manager.sv
